/* hdl/rsp_pkg.sv */
// Shared types, constants and GF(2^8) helpers for the RS parity encoder.
package rsp_pkg;

    typedef logic [7:0] t_byte;

    // Control broadcast to every remainder cell.
    typedef struct packed {
        logic  shift;
        t_byte fb;
    } t_cell_ctrl;

    localparam logic [8:0] GF_POLY = 9'h11d;
    localparam int MAX_PARITY = 64;

    function automatic t_byte gf_mul(t_byte a, t_byte b);
        logic [8:0] x;
        t_byte      acc;
        x   = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ x[7:0];
            x = {x[7:0], 1'b0};
            if (x[8]) x = x ^ GF_POLY;
        end
        return acc;
    endfunction

    // Coefficient of x^idx in the generator with roots alpha^1 .. alpha^p.
    function automatic t_byte gen_coef(int unsigned p, int unsigned idx);
        t_byte g [0:MAX_PARITY];
        t_byte root;
        for (int k = 0; k <= MAX_PARITY; k++) g[k] = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 1; i <= p; i++) begin
            root = gf_mul(root, 8'h02);
            for (int j = i; j > 0; j--) g[j] = g[j - 1] ^ gf_mul(g[j], root);
            g[0] = gf_mul(g[0], root);
        end
        return g[idx];
    endfunction

endpackage

/* hdl/rsp_ifs.sv */
// Valid/ready stream interfaces for message bytes and parity bytes.
interface rsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface rsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] parity_byte;
    logic       last_parity;

    modport source (output valid, output parity_byte, output last_parity, input ready);
    modport sink (input valid, input parity_byte, input last_parity, output ready);
endinterface

/* hdl/rsp_cell.sv */
// One remainder byte of the LFSR: takes its neighbor's byte plus a tap product.
module rsp_cell
    import rsp_pkg::*;
#(
    parameter logic [7:0] COEF = 8'h01
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_next,
    output t_byte      o_byte
);

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        n_byte = r_byte;
        if (i_ctrl.shift) n_byte = i_next ^ gf_mul(i_ctrl.fb, COEF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

/* hdl/rsp_chain.sv */
// Row of remainder cells; cell 0 holds the highest coefficient.
module rsp_chain
    import rsp_pkg::*;
#(
    parameter int PARITY_COUNT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    output t_byte      o_head
);

    t_byte w_cell [0:PARITY_COUNT];

    // Zero enters behind the last cell.
    assign w_cell[PARITY_COUNT] = '0;

    for (genvar j = 0; j < PARITY_COUNT; j++) begin : g_cell
        rsp_cell #(
            .COEF (gen_coef(PARITY_COUNT, PARITY_COUNT - 1 - j))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_next  (w_cell[j + 1]),
            .o_byte  (w_cell[j])
        );
    end

    assign o_head = w_cell[0];

endmodule

/* hdl/reed_solomon_parity_encoder.sv */
// Systematic RS(255,223) parity encoder, top level.
//
// Message bytes arrive on i_in (data_byte, last); parity bytes leave on o_out
// (parity_byte, last_parity). Each accepted byte updates a row of
// PARITY_COUNT remainder cells at once, so the block takes one message byte
// per cycle while i_in.ready is high. A codeword closes on a byte flagged
// last or on the DATA_COUNT-th byte. A short message is padded with zero
// bytes, one per cycle, while i_in.ready is low. Then PARITY_COUNT parity bytes
// are shown straight from the head cell, one per o_out transfer, the final one
// with last_parity. Each transfer shifts the row and clears it behind the data.
// Input is held off from the closing byte until the final parity transfer.
// The first parity byte follows the closing byte once any zero padding is done.
// If the receiver stalls, the parity byte holds and the block waits.
// Bytes after a full message that lacked last are taken and dropped up to and
// including the next byte flagged last.
// Reset clears the remainder cells, counters and drop flag; the block comes
// out of reset ready for input.
module reed_solomon_parity_encoder
    import rsp_pkg::*;
#(
    parameter int PARITY_COUNT = 32,
    parameter int DATA_COUNT   = 223
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsp_in_if.sink    i_in,
    rsp_out_if.source o_out
);

    localparam int CW = $clog2(DATA_COUNT + 1);
    localparam int IW = $clog2(PARITY_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_drop, n_drop;

    logic          w_in_xfer;
    logic          w_out_xfer;
    logic [CW:0]   w_count_inc;
    logic          w_full;
    logic          w_idx_last;
    t_byte         w_head;
    t_cell_ctrl    w_ctrl;

    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_xfer  = o_out.valid && o_out.ready;
    assign w_count_inc = {1'b0, r_count} + (CW + 1)'(1);
    assign w_full      = (w_count_inc == (CW + 1)'(DATA_COUNT));
    assign w_idx_last  = (r_idx == IW'(PARITY_COUNT - 1));

    rsp_chain #(
        .PARITY_COUNT (PARITY_COUNT)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_head  (w_head)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_drop      = r_drop;
        w_ctrl.shift = 1'b0;
        w_ctrl.fb    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (r_drop) begin
                        if (i_in.last) n_drop = 1'b0;
                    end else begin
                        w_ctrl.shift = 1'b1;
                        w_ctrl.fb    = i_in.data_byte ^ w_head;
                        if (w_full) begin
                            n_state = ST_EMIT;
                            n_count = '0;
                            n_drop  = !i_in.last;
                        end else begin
                            n_count = w_count_inc[CW-1:0];
                            if (i_in.last) n_state = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD: begin
                // zero byte in: feedback is the head alone
                w_ctrl.shift = 1'b1;
                w_ctrl.fb    = w_head;
                if (w_full) begin
                    n_state = ST_EMIT;
                    n_count = '0;
                end else begin
                    n_count = w_count_inc[CW-1:0];
                end
            end
            ST_EMIT: begin
                if (w_out_xfer) begin
                    // plain shift toward the head, zeros fill from the tail
                    w_ctrl.shift = 1'b1;
                    if (w_idx_last) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_drop  <= n_drop;
        end
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_EMIT);
    assign o_out.parity_byte = w_head;
    assign o_out.last_parity = w_idx_last;

endmodule

/* hdl/rsp_checker.sv */
// Port-level checks for the RS parity encoder, bound to the top level.
module rsp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // Input is never taken while parity is being shown.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while parity valid");

    // A parity run does not break before its final byte.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> i_out_valid)
        else $error("parity run broke early");

    // The final parity transfer ends the run and reopens input.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (!i_out_valid && i_in_ready))
        else $error("parity run did not end after final byte");

    // A stalled parity byte holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("stalled parity byte changed");

    // Out of reset the block is ready and shows nothing.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

endmodule

bind reed_solomon_parity_encoder rsp_checker u_rsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.parity_byte),
    .i_out_last  (o_out.last_parity)
);

/* test/tb_reed_solomon_parity_encoder.sv */
`timescale 1ns / 100ps
// Testbench for the RS(255,223) parity encoder: bit-true parity prediction and stream checks.
module tb_reed_solomon_parity_encoder;
    import rsp_pkg::*;

    localparam int PAR_N          = 32;
    localparam int DAT_N          = 223;
    localparam logic [8:0] FIELD_POLY = 9'h11d;
    localparam int HOLD_LEN       = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BYTES   = 60;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    typedef struct {
        t_byte value;
        logic  fin;
    } t_parity;

    logic i_clk;
    logic i_rst_n;

    rsp_in_if  msg_if ();
    rsp_out_if par_if ();

    reed_solomon_parity_encoder #(
        .PARITY_COUNT(PAR_N),
        .DATA_COUNT  (DAT_N)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (msg_if),
        .o_out  (par_if)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor
    t_byte gf_exp [0:509];
    t_byte gf_log [0:255];
    t_byte taps [0:PAR_N];            // generator, index = power of x
    t_byte cw_remainder [0:PAR_N-1];
    int    cw_len;
    bit    dropping_tail;
    t_parity parity_due [$];

    function automatic t_byte gf_times(t_byte a, t_byte b);
        if (a == 0 || b == 0) return 8'h00;
        return gf_exp[int'(gf_log[a]) + int'(gf_log[b])];
    endfunction

    function automatic void build_field();
        logic [8:0] x;
        x = 9'h001;
        for (int i = 0; i < 255; i++) begin
            gf_exp[i]       = x[7:0];
            gf_exp[i + 255] = x[7:0];
            gf_log[x[7:0]]  = t_byte'(i);
            x = x << 1;
            if (x[8]) x = x ^ FIELD_POLY;
        end
        gf_log[0] = 8'h00;
        for (int k = 0; k <= PAR_N; k++) taps[k] = 8'h00;
        taps[0] = 8'h01;
        // multiply out (x + a^i) for i = 1 .. PAR_N
        for (int i = 1; i <= PAR_N; i++) begin
            for (int j = i; j > 0; j--) taps[j] = taps[j - 1] ^ gf_times(taps[j], gf_exp[i]);
            taps[0] = gf_times(taps[0], gf_exp[i]);
        end
        for (int k = 0; k < PAR_N; k++) cw_remainder[k] = 8'h00;
        cw_len        = 0;
        dropping_tail = 1'b0;
    endfunction

    function automatic void lfsr_shift(t_byte d);
        t_byte fb;
        fb = d ^ cw_remainder[0];
        for (int j = 0; j < PAR_N - 1; j++)
            cw_remainder[j] = cw_remainder[j + 1] ^ gf_times(fb, taps[PAR_N - 1 - j]);
        cw_remainder[PAR_N - 1] = gf_times(fb, taps[0]);
    endfunction

    // Returns 1 when the byte entered the codeword, 0 when it was dropped.
    function automatic bit encode_byte(t_byte d, logic l);
        t_parity due_item;
        if (dropping_tail) begin
            if (l) dropping_tail = 1'b0;
            return 1'b0;
        end
        lfsr_shift(d);
        cw_len++;
        if (!l && cw_len < DAT_N) return 1'b1;
        while (cw_len < DAT_N) begin
            lfsr_shift(8'h00);
            cw_len++;
        end
        for (int k = 0; k < PAR_N; k++) begin
            due_item.value = cw_remainder[k];
            due_item.fin   = (k == PAR_N - 1);
            parity_due.insert(parity_due.size(), due_item);
            cw_remainder[k] = 8'h00;
        end
        cw_len        = 0;
        dropping_tail = !l;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- sender
    bit tx_bursty;
    int burst_left;
    int bytes_taken_total;

    task automatic send_byte(input t_byte d, input logic l);
        int gap;
        msg_if.valid     <= 1'b1;
        msg_if.data_byte <= d;
        msg_if.last      <= l;
        do @(posedge i_clk); while (!msg_if.ready);
        if (encode_byte(d, l)) bytes_taken_total++;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 16);
                msg_if.valid     <= 1'b0;
                msg_if.data_byte <= t_byte'($urandom);
                msg_if.last      <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_message(input int len, input bit close);
        for (int i = 0; i < len; i++) send_byte(t_byte'($urandom), close && (i == len - 1));
    endtask

    // ---------------------------------------------------------------- receiver / checker
    t_rx_mode rx_mode;
    int       hold_token;
    int       hold_seen;
    int       hold_left;
    logic [15:0] rx_pattern;
    logic [3:0]  rx_phase;
    int       fail_count;
    t_parity  rx_expect;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            par_if.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
            rx_phase     <= '0;
            rx_pattern   <= 16'hb5a7;
        end else begin
            if (par_if.valid && par_if.ready) begin
                if (parity_due.size() == 0) begin
                    $error("parity_byte: expected none, got %02h (last_parity %0b)",
                           par_if.parity_byte, par_if.last_parity);
                    fail_count++;
                end else begin
                    rx_expect = parity_due.pop_front();
                    if (par_if.parity_byte !== rx_expect.value) begin
                        $error("parity_byte: expected %02h, got %02h",
                               rx_expect.value, par_if.parity_byte);
                        fail_count++;
                    end
                    if (par_if.last_parity !== rx_expect.fin) begin
                        $error("last_parity: expected %0b, got %0b",
                               rx_expect.fin, par_if.last_parity);
                        fail_count++;
                    end
                end
            end
            rx_phase <= rx_phase + 1'b1;
            if (rx_phase == 4'hf) rx_pattern <= 16'($urandom) | 16'h0001;
            if (hold_token != hold_seen) begin
                // long hold-off, counted here
                hold_seen    <= hold_token;
                hold_left    <= HOLD_LEN;
                par_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                par_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:  par_if.ready <= 1'b1;
                    RX_RANDOM:  par_if.ready <= ($urandom_range(0, 99) >= 35);
                    RX_PATTERN: par_if.ready <= rx_pattern[rx_phase];
                    default:    par_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    int idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_if.valid && msg_if.ready) || (par_if.valid && par_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- tests
    // Shortest messages at the data extremes, with heavy zero padding.
    task automatic test_single_byte();
        tx_bursty = 1'b0;
        rx_mode <= RX_ALWAYS;
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
    endtask

    // Walking one and alternating patterns; every data bit seen at 0 and 1.
    task automatic test_short_patterns();
        tx_bursty = 1'b1;
        rx_mode <= RX_PATTERN;
        for (int i = 0; i < 8; i++) send_byte(t_byte'(1 << i), i == 7);
        send_byte(8'haa, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // Full message without last, then dropped tail, then a short message.
    task automatic test_full_message();
        tx_bursty = 1'b0;
        rx_mode <= RX_RANDOM;
        send_message(DAT_N, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hed, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        send_message(3, 1'b1);
    endtask

    // Receiver holds off long enough that parity backs up and input stalls.
    task automatic test_backpressure();
        tx_bursty = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_token <= hold_token + 1;
        send_message($urandom_range(8, 12), 1'b1);
        send_message($urandom_range(8, 12), 1'b1);
        send_message($urandom_range(1, 4), 1'b1);
    endtask

    task automatic test_random();
        int start;
        start = bytes_taken_total;
        while (bytes_taken_total - start < RANDOM_BYTES) begin
            tx_bursty = ($urandom_range(0, 3) != 0);
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            send_message($urandom_range(1, 24), 1'b1);
        end
    endtask

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        msg_if.valid      = 1'b0;
        msg_if.data_byte  = 8'h00;
        msg_if.last       = 1'b0;
        rx_mode           = RX_ALWAYS;
        hold_token        = 0;
        tx_bursty         = 1'b0;
        burst_left        = 0;
        bytes_taken_total = 0;
        fail_count        = 0;
        build_field();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte();
        test_short_patterns();
        test_full_message();
        test_backpressure();
        test_random();

        msg_if.valid <= 1'b0;
        rx_mode <= RX_ALWAYS;
        while (parity_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/rsp_pkg.sv
hdl/rsp_ifs.sv
hdl/rsp_cell.sv
hdl/rsp_chain.sv
hdl/reed_solomon_parity_encoder.sv
hdl/rsp_checker.sv
test/tb_reed_solomon_parity_encoder.sv
